### design/d2q9_bgk_cell_collide_macros.svh
// Assertion macros used by the collision engine checker.
`ifndef D2Q9_BGK_CELL_COLLIDE_MACROS_SVH
`define D2Q9_BGK_CELL_COLLIDE_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define D2Q9_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("d2q9 check failed");

// Next-cycle implication, checked only out of reset.
`define D2Q9_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("d2q9 check failed");

// Condition that must hold in the cycle after reset is applied.
`define D2Q9_ASSERT_RESET(lbl, cons) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("d2q9 reset check failed");

`endif

### design/d2q9_pkg.sv
// Types, widths and helper functions of the D2Q9 collision engine.
package d2q9_pkg;

    localparam int D2Q9_DIRS        = 9;
    localparam int D2Q9_F_W         = 16;
    localparam int D2Q9_OMEGA_W     = 15;
    localparam logic [D2Q9_OMEGA_W-1:0] D2Q9_OMEGA_RESET = 15'd16384;
    localparam int D2Q9_ADDR_W      = 3;
    localparam int D2Q9_DATA_W      = 32;
    localparam logic D2Q9_REG_OMEGA = 1'b0;
    localparam int D2Q9_QUEUE_DEPTH = 4;

    localparam int D2Q9_SUM_W       = 20;
    localparam int D2Q9_MOM_W       = 19;
    localparam int D2Q9_DEN_W       = 19;
    localparam int D2Q9_NUM_W       = 35;
    localparam int D2Q9_DIV_STEPS   = 16;
    localparam int D2Q9_DIV_LAT     = D2Q9_DIV_STEPS + 1;
    localparam int D2Q9_CU_W        = 18;
    localparam int D2Q9_SQ_W        = 34;
    localparam int D2Q9_T_W         = 38;
    localparam int D2Q9_TL_W        = 19;
    localparam int D2Q9_PL_W        = 36;
    localparam int D2Q9_PH_W        = 35;
    localparam int D2Q9_X_W         = 58;
    localparam int D2Q9_X_SH        = 31;
    localparam int D2Q9_Z_W         = D2Q9_X_W - D2Q9_X_SH;
    localparam int D2Q9_RCP_W       = 26;
    localparam logic [D2Q9_RCP_W-1:0] D2Q9_RCP9 = 26'd59652323;
    localparam int D2Q9_RCP_SH      = 29;
    localparam int D2Q9_PROD_W      = D2Q9_Z_W + D2Q9_RCP_W;
    localparam int D2Q9_Q_W         = D2Q9_PROD_W - D2Q9_RCP_SH;
    localparam int D2Q9_FEQ_W       = D2Q9_Q_W + 1;
    localparam int D2Q9_D_W         = 27;
    localparam int D2Q9_OMP_W       = D2Q9_OMEGA_W + 1 + D2Q9_D_W;
    localparam int D2Q9_G_W         = 30;
    localparam int D2Q9_BACK_STAGES = D2Q9_DIV_LAT + 9;

    typedef logic signed [D2Q9_F_W-1:0] t_q14;
    typedef t_q14 t_dist [D2Q9_DIRS];
    typedef logic signed [1:0] t_dir;

    typedef struct {
        t_dist                          f;
        logic                           wall;
        logic signed [D2Q9_SUM_W-1:0]   sum;
        logic signed [D2Q9_MOM_W-1:0]   mx;
        logic signed [D2Q9_MOM_W-1:0]   my;
    } t_cell;

    function automatic t_dir dir_cx(input int unsigned k);
        unique case (k)
            1, 5, 8: dir_cx = 2'sd1;
            3, 6, 7: dir_cx = -2'sd1;
            default: dir_cx = 2'sd0;
        endcase
    endfunction

    function automatic t_dir dir_cy(input int unsigned k);
        unique case (k)
            2, 5, 6: dir_cy = 2'sd1;
            4, 7, 8: dir_cy = -2'sd1;
            default: dir_cy = 2'sd0;
        endcase
    endfunction

    // Shift that applies the weight in units of 1/36 (16, 4 or 1).
    function automatic logic [2:0] dir_wsh(input int unsigned k);
        unique case (k)
            0:          dir_wsh = 3'd4;
            1, 2, 3, 4: dir_wsh = 3'd2;
            default:    dir_wsh = 3'd0;
        endcase
    endfunction

    function automatic int unsigned bounce_of(input int unsigned k);
        unique case (k)
            1:       bounce_of = 3;
            2:       bounce_of = 4;
            3:       bounce_of = 1;
            4:       bounce_of = 2;
            5:       bounce_of = 7;
            6:       bounce_of = 8;
            7:       bounce_of = 5;
            8:       bounce_of = 6;
            default: bounce_of = 0;
        endcase
    endfunction

    function automatic t_q14 sat16(input logic signed [31:0] v);
        if (v > 32'sd32767) begin
            sat16 = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = v[D2Q9_F_W-1:0];
        end
    endfunction

endpackage

### design/d2q9_bgk_cell_collide.sv
// Throughput: one item per cycle while results are popped; the two 16-stage velocity dividers and the
// fully pipelined equilibrium path all advance together, and all stall together when a result is held.
// A result that is not popped holds the whole back pipeline; the front queue absorbs inputs.
// Reset is synchronous, active low; it empties all stages and sets omega to 1.0.
module d2q9_bgk_cell_collide import d2q9_pkg::*; #(
    parameter int QUEUE_DEPTH = D2Q9_QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  t_q14                    i_f_rest,
    input  t_q14                    i_f_east,
    input  t_q14                    i_f_north,
    input  t_q14                    i_f_west,
    input  t_q14                    i_f_south,
    input  t_q14                    i_f_northeast,
    input  t_q14                    i_f_northwest,
    input  t_q14                    i_f_southwest,
    input  t_q14                    i_f_southeast,
    input  logic                    i_is_wall,
    output logic                    empty,
    input  logic                    pop,
    output t_q14                    o_g_rest,
    output t_q14                    o_g_east,
    output t_q14                    o_g_north,
    output t_q14                    o_g_west,
    output t_q14                    o_g_south,
    output t_q14                    o_g_northeast,
    output t_q14                    o_g_northwest,
    output t_q14                    o_g_southwest,
    output t_q14                    o_g_southeast,
    output t_q14                    o_density,
    output t_q14                    o_vel_x,
    output t_q14                    o_vel_y,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [D2Q9_ADDR_W-1:0]  paddr,
    input  logic [D2Q9_DATA_W-1:0]  pwdata,
    output logic [D2Q9_DATA_W-1:0]  prdata,
    output logic                    pready
);

    logic [D2Q9_OMEGA_W-1:0] r_omega;

    assign pready = 1'b1;
    assign prdata = (paddr[D2Q9_ADDR_W-1] == D2Q9_REG_OMEGA) ? D2Q9_DATA_W'(r_omega) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_omega <= D2Q9_OMEGA_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[D2Q9_ADDR_W-1] == D2Q9_REG_OMEGA) begin
            r_omega <= pwdata[D2Q9_OMEGA_W-1:0];
        end
    end

    t_dist f_in;
    t_dist g_out;
    t_cell front_cell;
    t_cell head_cell;
    logic  front_valid;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    logic  back_valid;

    assign f_in[0] = i_f_rest;
    assign f_in[1] = i_f_east;
    assign f_in[2] = i_f_north;
    assign f_in[3] = i_f_west;
    assign f_in[4] = i_f_south;
    assign f_in[5] = i_f_northeast;
    assign f_in[6] = i_f_northwest;
    assign f_in[7] = i_f_southwest;
    assign f_in[8] = i_f_southeast;

    d2q9_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_f      (f_in),
        .i_wall   (i_is_wall),
        .o_full   (full),
        .o_valid  (front_valid),
        .o_cell   (front_cell),
        .i_q_full (q_full)
    );

    d2q9_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cell  (front_cell),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cell  (head_cell),
        .o_empty (q_empty)
    );

    d2q9_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_cell),
        .i_head_valid (!q_empty),
        .o_pop_q      (q_pop),
        .i_omega      (r_omega),
        .o_valid      (back_valid),
        .i_pop        (pop),
        .o_g          (g_out),
        .o_density    (o_density),
        .o_vel_x      (o_vel_x),
        .o_vel_y      (o_vel_y)
    );

    assign empty         = !back_valid;
    assign o_g_rest      = g_out[0];
    assign o_g_east      = g_out[1];
    assign o_g_north     = g_out[2];
    assign o_g_west      = g_out[3];
    assign o_g_south     = g_out[4];
    assign o_g_northeast = g_out[5];
    assign o_g_northwest = g_out[6];
    assign o_g_southwest = g_out[7];
    assign o_g_southeast = g_out[8];

endmodule

### design/d2q9_front.sv
// Front stage: takes a cell item and forms its density and momentum sums.
module d2q9_front import d2q9_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_dist i_f,
    input  logic  i_wall,
    output logic  o_full,
    output logic  o_valid,
    output t_cell o_cell,
    input  logic  i_q_full
);

    logic  r_valid;
    t_cell r_cell;
    t_cell n_cell;

    always_comb begin
        n_cell.f    = i_f;
        n_cell.wall = i_wall;
        n_cell.sum  = ((D2Q9_SUM_W'(i_f[0]) + D2Q9_SUM_W'(i_f[1]))
                    + (D2Q9_SUM_W'(i_f[2]) + D2Q9_SUM_W'(i_f[3])))
                    + ((D2Q9_SUM_W'(i_f[4]) + D2Q9_SUM_W'(i_f[5]))
                    + (D2Q9_SUM_W'(i_f[6]) + D2Q9_SUM_W'(i_f[7])))
                    + D2Q9_SUM_W'(i_f[8]);
        n_cell.mx   = (D2Q9_MOM_W'(i_f[1]) + D2Q9_MOM_W'(i_f[5]) + D2Q9_MOM_W'(i_f[8]))
                    - (D2Q9_MOM_W'(i_f[3]) + D2Q9_MOM_W'(i_f[6]) + D2Q9_MOM_W'(i_f[7]));
        n_cell.my   = (D2Q9_MOM_W'(i_f[2]) + D2Q9_MOM_W'(i_f[5]) + D2Q9_MOM_W'(i_f[6]))
                    - (D2Q9_MOM_W'(i_f[4]) + D2Q9_MOM_W'(i_f[7]) + D2Q9_MOM_W'(i_f[8]));
    end

    assign o_full  = r_valid && i_q_full;
    assign o_valid = r_valid;
    assign o_cell  = r_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_full) begin
            r_valid <= i_push;
        end
        if (i_push && !o_full) begin
            r_cell <= n_cell;
        end
    end

endmodule

### design/d2q9_fifo.sv
// Short queue between the front stage and the collision pipeline.
module d2q9_fifo import d2q9_pkg::*; #(
    parameter int DEPTH = D2Q9_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cell i_cell,
    output logic  o_full,
    input  logic  i_pop,
    output t_cell o_cell,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cell             r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push_ok;
    logic              pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_cell  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push_ok) begin
            r_slot[r_wr_ptr] <= i_cell;
        end
    end

endmodule

### design/d2q9_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module d2q9_div import d2q9_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [D2Q9_NUM_W-1:0]  i_num,
    input  logic [D2Q9_DEN_W-1:0]  i_den,
    output logic [D2Q9_F_W-1:0]    o_quot
);

    localparam int STEPS = D2Q9_DIV_STEPS;

    logic [D2Q9_NUM_W-1:0] r_rem  [STEPS+1];
    logic [D2Q9_DEN_W-1:0] r_den  [STEPS+1];
    logic [STEPS-1:0]      r_quot [STEPS+1];
    logic [D2Q9_NUM_W-1:0] n_rem  [STEPS];
    logic [STEPS-1:0]      n_quot [STEPS];

    always_comb begin
        for (int k = 0; k < STEPS; k++) begin
            logic [D2Q9_NUM_W-1:0] shifted;
            shifted = D2Q9_NUM_W'(r_den[k]) << (STEPS - 1 - k);
            if (r_rem[k] >= shifted) begin
                n_rem[k]  = r_rem[k] - shifted;
                n_quot[k] = {r_quot[k][STEPS-2:0], 1'b1};
            end else begin
                n_rem[k]  = r_rem[k];
                n_quot[k] = {r_quot[k][STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
            r_quot[0] <= '0;
            for (int k = 0; k < STEPS; k++) begin
                r_rem[k+1]  <= n_rem[k];
                r_den[k+1]  <= r_den[k];
                r_quot[k+1] <= n_quot[k];
            end
        end
    end

    assign o_quot = r_quot[STEPS];

endmodule

### design/d2q9_back.sv
// Collision pipeline: velocities, equilibrium, relaxation and bounce-back.
module d2q9_back import d2q9_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell                    i_head,
    input  logic                     i_head_valid,
    output logic                     o_pop_q,
    input  logic [D2Q9_OMEGA_W-1:0]  i_omega,
    output logic                     o_valid,
    input  logic                     i_pop,
    output t_dist                    o_g,
    output t_q14                     o_density,
    output t_q14                     o_vel_x,
    output t_q14                     o_vel_y
);

    localparam int NSTG = D2Q9_BACK_STAGES;
    localparam int DL   = D2Q9_DIV_LAT;

    typedef struct {
        t_dist f;
        logic  wall;
        t_q14  rho;
        logic  pos;
        logic  negx;
        logic  negy;
        logic  ovfx;
        logic  ovfy;
    } t_side;

    logic [NSTG-1:0] r_vld;
    logic            en;

    assign en      = !r_vld[NSTG-1] || i_pop;
    assign o_pop_q = en && i_head_valid;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], o_pop_q};
        end
    end

    // Division operands for the two velocities.
    t_side                  n_side;
    logic [D2Q9_NUM_W-1:0]  num_x;
    logic [D2Q9_NUM_W-1:0]  num_y;
    logic [D2Q9_DEN_W-1:0]  den;
    logic [D2Q9_F_W-1:0]    quot_x;
    logic [D2Q9_F_W-1:0]    quot_y;

    always_comb begin
        logic [D2Q9_MOM_W-1:0]  mag_x;
        logic [D2Q9_MOM_W-1:0]  mag_y;
        logic [D2Q9_NUM_W-1:0]  half;
        logic [D2Q9_NUM_W-1:0]  lim;
        mag_x = i_head.mx[D2Q9_MOM_W-1] ? -i_head.mx : i_head.mx;
        mag_y = i_head.my[D2Q9_MOM_W-1] ? -i_head.my : i_head.my;
        den   = i_head.sum[D2Q9_DEN_W-1:0];
        half  = D2Q9_NUM_W'(i_head.sum[D2Q9_SUM_W-1:1]);
        num_x = (D2Q9_NUM_W'(mag_x) << 14) + half;
        num_y = (D2Q9_NUM_W'(mag_y) << 14) + half;
        lim   = D2Q9_NUM_W'(den) << D2Q9_DIV_STEPS;
        n_side.f    = i_head.f;
        n_side.wall = i_head.wall;
        n_side.rho  = sat16(32'(i_head.sum));
        n_side.pos  = (i_head.sum > D2Q9_SUM_W'(0));
        n_side.negx = i_head.mx[D2Q9_MOM_W-1];
        n_side.negy = i_head.my[D2Q9_MOM_W-1];
        n_side.ovfx = (num_x >= lim);
        n_side.ovfy = (num_y >= lim);
    end

    d2q9_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (num_x),
        .i_den  (den),
        .o_quot (quot_x)
    );

    d2q9_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (num_y),
        .i_den  (den),
        .o_quot (quot_y)
    );

    t_side r_side [DL];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < DL; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    function automatic t_q14 vel_of(input logic pos, input logic neg, input logic ovf,
                                    input logic [D2Q9_F_W-1:0] q);
        logic [D2Q9_F_W:0] nq;
        nq = '0 - {1'b0, q};
        if (!pos) begin
            vel_of = '0;
        end else if (neg) begin
            vel_of = (ovf || q > 16'd32768) ? 16'sh8000 : nq[D2Q9_F_W-1:0];
        end else begin
            vel_of = (ovf || q[D2Q9_F_W-1]) ? 16'sh7FFF : q;
        end
    endfunction

    // Stage 1: saturated velocities.
    t_dist r1_f;
    logic  r1_wall;
    t_q14  r1_rho;
    t_q14  r1_ux;
    t_q14  r1_uy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_f    <= r_side[DL-1].f;
            r1_wall <= r_side[DL-1].wall;
            r1_rho  <= r_side[DL-1].rho;
            r1_ux   <= vel_of(r_side[DL-1].pos, r_side[DL-1].negx, r_side[DL-1].ovfx, quot_x);
            r1_uy   <= vel_of(r_side[DL-1].pos, r_side[DL-1].negy, r_side[DL-1].ovfy, quot_y);
        end
    end

    // Stage 2: squares of the velocity components and their sum and difference.
    t_dist                        r2_f;
    logic                         r2_wall;
    t_q14                         r2_rho;
    t_q14                         r2_ux;
    t_q14                         r2_uy;
    logic signed [D2Q9_SQ_W-1:0]  r2_sqx;
    logic signed [D2Q9_SQ_W-1:0]  r2_sqy;
    logic signed [D2Q9_SQ_W-1:0]  r2_sqp;
    logic signed [D2Q9_SQ_W-1:0]  r2_sqm;

    always_ff @(posedge i_clk) begin
        logic signed [D2Q9_F_W:0] vp;
        logic signed [D2Q9_F_W:0] vm;
        vp = (D2Q9_F_W+1)'(r1_ux) + (D2Q9_F_W+1)'(r1_uy);
        vm = (D2Q9_F_W+1)'(r1_ux) - (D2Q9_F_W+1)'(r1_uy);
        if (en) begin
            r2_f    <= r1_f;
            r2_wall <= r1_wall;
            r2_rho  <= r1_rho;
            r2_ux   <= r1_ux;
            r2_uy   <= r1_uy;
            // Widen before multiplying so the square keeps all of its bits.
            r2_sqx  <= D2Q9_SQ_W'(32'(r1_ux) * 32'(r1_ux));
            r2_sqy  <= D2Q9_SQ_W'(32'(r1_uy) * 32'(r1_uy));
            r2_sqp  <= vp * vp;
            r2_sqm  <= vm * vm;
        end
    end

    // Stage 3: twice the bracket of the equilibrium, in Q28, per direction.
    logic signed [D2Q9_T_W-1:0] n3_t [D2Q9_DIRS];

    always_comb begin
        logic signed [D2Q9_T_W-1:0] uu;
        uu = D2Q9_T_W'(r2_sqx) + D2Q9_T_W'(r2_sqy);
        for (int k = 0; k < D2Q9_DIRS; k++) begin
            logic signed [D2Q9_CU_W-1:0] cu;
            logic signed [D2Q9_T_W-1:0]  cue;
            logic signed [D2Q9_T_W-1:0]  sq;
            cu = '0;
            if (dir_cx(k) == 2'sd1)  cu = cu + D2Q9_CU_W'(r2_ux);
            if (dir_cx(k) == -2'sd1) cu = cu - D2Q9_CU_W'(r2_ux);
            if (dir_cy(k) == 2'sd1)  cu = cu + D2Q9_CU_W'(r2_uy);
            if (dir_cy(k) == -2'sd1) cu = cu - D2Q9_CU_W'(r2_uy);
            if (dir_cx(k) == 2'sd0 && dir_cy(k) == 2'sd0) begin
                sq = '0;
            end else if (dir_cy(k) == 2'sd0) begin
                sq = D2Q9_T_W'(r2_sqx);
            end else if (dir_cx(k) == 2'sd0) begin
                sq = D2Q9_T_W'(r2_sqy);
            end else if (dir_cx(k) == dir_cy(k)) begin
                sq = D2Q9_T_W'(r2_sqp);
            end else begin
                sq = D2Q9_T_W'(r2_sqm);
            end
            cue     = D2Q9_T_W'(cu) <<< 14;
            n3_t[k] = (D2Q9_T_W'(1) <<< 29)
                    + ((cue <<< 2) + (cue <<< 1))
                    + ((sq <<< 3) + sq)
                    - ((uu <<< 1) + uu);
        end
    end

    t_dist                        r3_f;
    logic                         r3_wall;
    t_q14                         r3_rho;
    t_q14                         r3_ux;
    t_q14                         r3_uy;
    logic signed [D2Q9_T_W-1:0]   r3_t [D2Q9_DIRS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_f    <= r2_f;
            r3_wall <= r2_wall;
            r3_rho  <= r2_rho;
            r3_ux   <= r2_ux;
            r3_uy   <= r2_uy;
            r3_t    <= n3_t;
        end
    end

    // Stage 4: density times the bracket, as two partial products.
    t_dist                        r4_f;
    logic                         r4_wall;
    t_q14                         r4_rho;
    t_q14                         r4_ux;
    t_q14                         r4_uy;
    logic signed [D2Q9_PL_W-1:0]  r4_pl [D2Q9_DIRS];
    logic signed [D2Q9_PH_W-1:0]  r4_ph [D2Q9_DIRS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_f    <= r3_f;
            r4_wall <= r3_wall;
            r4_rho  <= r3_rho;
            r4_ux   <= r3_ux;
            r4_uy   <= r3_uy;
            for (int k = 0; k < D2Q9_DIRS; k++) begin
                r4_pl[k] <= r3_rho * $signed({1'b0, r3_t[k][D2Q9_TL_W-1:0]});
                r4_ph[k] <= r3_rho * $signed(r3_t[k][D2Q9_T_W-1:D2Q9_TL_W]);
            end
        end
    end

    // Stage 5: weighted product, rounding bias and the power-of-two part of 1/72.
    logic [D2Q9_Z_W-1:0] n5_z   [D2Q9_DIRS];
    logic                n5_neg [D2Q9_DIRS];

    always_comb begin
        for (int k = 0; k < D2Q9_DIRS; k++) begin
            logic signed [D2Q9_X_W-1:0] x;
            logic [D2Q9_X_W-1:0]        mag;
            x       = ((D2Q9_X_W'(r4_ph[k]) <<< D2Q9_TL_W) + D2Q9_X_W'(r4_pl[k]))
                    <<< dir_wsh(k);
            n5_neg[k] = x[D2Q9_X_W-1];
            mag     = n5_neg[k] ? -x : x;
            mag     = mag + (D2Q9_X_W'(9) << 30);
            n5_z[k] = mag[D2Q9_X_W-1:D2Q9_X_SH];
        end
    end

    t_dist               r5_f;
    logic                r5_wall;
    t_q14                r5_rho;
    t_q14                r5_ux;
    t_q14                r5_uy;
    logic [D2Q9_Z_W-1:0] r5_z   [D2Q9_DIRS];
    logic                r5_neg [D2Q9_DIRS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_f    <= r4_f;
            r5_wall <= r4_wall;
            r5_rho  <= r4_rho;
            r5_ux   <= r4_ux;
            r5_uy   <= r4_uy;
            r5_z    <= n5_z;
            r5_neg  <= n5_neg;
        end
    end

    // Stage 6: reciprocal multiply for the division by nine.
    t_dist                  r6_f;
    logic                   r6_wall;
    t_q14                   r6_rho;
    t_q14                   r6_ux;
    t_q14                   r6_uy;
    logic [D2Q9_Z_W-1:0]    r6_z    [D2Q9_DIRS];
    logic                   r6_neg  [D2Q9_DIRS];
    logic [D2Q9_PROD_W-1:0] r6_prod [D2Q9_DIRS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_f    <= r5_f;
            r6_wall <= r5_wall;
            r6_rho  <= r5_rho;
            r6_ux   <= r5_ux;
            r6_uy   <= r5_uy;
            r6_z    <= r5_z;
            r6_neg  <= r5_neg;
            for (int k = 0; k < D2Q9_DIRS; k++) begin
                r6_prod[k] <= D2Q9_PROD_W'(r5_z[k]) * D2Q9_PROD_W'(D2Q9_RCP9);
            end
        end
    end

    // Stage 7: the estimate is short by at most one; fix it and form f - feq.
    logic signed [D2Q9_D_W-1:0] n7_d [D2Q9_DIRS];

    always_comb begin
        for (int k = 0; k < D2Q9_DIRS; k++) begin
            logic [D2Q9_Q_W-1:0]          qe;
            logic [D2Q9_Q_W-1:0]          q;
            logic [D2Q9_Z_W-1:0]          rem;
            logic signed [D2Q9_FEQ_W-1:0] feq;
            qe  = r6_prod[k][D2Q9_PROD_W-1:D2Q9_RCP_SH];
            rem = r6_z[k] - ((D2Q9_Z_W'(qe) << 3) + D2Q9_Z_W'(qe));
            q   = (rem >= D2Q9_Z_W'(9)) ? qe + 1'b1 : qe;
            feq = r6_neg[k] ? -$signed({1'b0, q}) : $signed({1'b0, q});
            n7_d[k] = D2Q9_D_W'(r6_f[k]) - D2Q9_D_W'(feq);
        end
    end

    t_dist                        r7_f;
    logic                         r7_wall;
    t_q14                         r7_rho;
    t_q14                         r7_ux;
    t_q14                         r7_uy;
    logic signed [D2Q9_D_W-1:0]   r7_d [D2Q9_DIRS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_f    <= r6_f;
            r7_wall <= r6_wall;
            r7_rho  <= r6_rho;
            r7_ux   <= r6_ux;
            r7_uy   <= r6_uy;
            r7_d    <= n7_d;
        end
    end

    // Stage 8: scale the deviation by omega.
    t_dist                          r8_f;
    logic                           r8_wall;
    t_q14                           r8_rho;
    t_q14                           r8_ux;
    t_q14                           r8_uy;
    logic signed [D2Q9_OMP_W-1:0]   r8_p [D2Q9_DIRS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_f    <= r7_f;
            r8_wall <= r7_wall;
            r8_rho  <= r7_rho;
            r8_ux   <= r7_ux;
            r8_uy   <= r7_uy;
            for (int k = 0; k < D2Q9_DIRS; k++) begin
                r8_p[k] <= $signed({1'b0, i_omega}) * r7_d[k];
            end
        end
    end

    // Stage 9: round, relax and saturate; wall cells swap opposite directions.
    t_dist n9_g;

    always_comb begin
        for (int k = 0; k < D2Q9_DIRS; k++) begin
            logic [D2Q9_OMP_W-1:0]        mag;
            logic signed [D2Q9_G_W-1:0]   rnd;
            logic signed [D2Q9_G_W-1:0]   g;
            mag = r8_p[k][D2Q9_OMP_W-1] ? -r8_p[k] : r8_p[k];
            mag = mag + D2Q9_OMP_W'(8192);
            rnd = $signed({1'b0, mag[D2Q9_G_W+12:14]});
            if (r8_p[k][D2Q9_OMP_W-1]) begin
                rnd = -rnd;
            end
            g = D2Q9_G_W'(r8_f[k]) - rnd;
            n9_g[k] = r8_wall ? r8_f[bounce_of(k)] : sat16(32'(g));
        end
    end

    t_dist r9_g;
    t_q14  r9_rho;
    t_q14  r9_ux;
    t_q14  r9_uy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_g   <= n9_g;
            r9_rho <= r8_wall ? '0 : r8_rho;
            r9_ux  <= r8_wall ? '0 : r8_ux;
            r9_uy  <= r8_wall ? '0 : r8_uy;
        end
    end

    assign o_g       = r9_g;
    assign o_density = r9_rho;
    assign o_vel_x   = r9_ux;
    assign o_vel_y   = r9_uy;

endmodule

### design/d2q9_checker.sv
// Port-level checks of the collision engine, bound to its top level.
`include "d2q9_bgk_cell_collide_macros.svh"

module d2q9_checker import d2q9_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    full,
    input logic                    empty,
    input logic                    pop,
    input t_q14                    o_g_rest,
    input t_q14                    o_density,
    input t_q14                    o_vel_x,
    input t_q14                    o_vel_y,
    input logic                    psel,
    input logic                    penable,
    input logic                    pwrite,
    input logic [D2Q9_ADDR_W-1:0]  paddr,
    input logic [D2Q9_DATA_W-1:0]  pwdata,
    input logic [D2Q9_DATA_W-1:0]  prdata,
    input logic                    pready
);

    `D2Q9_ASSERT_RESET(a_reset_drains, empty && !full)

    `D2Q9_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(o_g_rest) && $stable(o_density) && $stable(o_vel_x) && $stable(o_vel_y))

    // A density that is not positive means the velocities were never divided out.
    `D2Q9_ASSERT_SAME(a_no_flow_without_mass, !empty && (o_density[15] || o_density == 16'sd0), o_vel_x == 16'sd0 && o_vel_y == 16'sd0)

    `D2Q9_ASSERT_NEXT(a_omega_readback, psel && penable && pwrite && pready && paddr[2] == 1'b0, paddr[2] != 1'b0 || prdata[14:0] == $past(pwdata[14:0]))

    `D2Q9_ASSERT_SAME(a_always_ready, 1'b1, pready)

endmodule

bind d2q9_bgk_cell_collide d2q9_checker u_d2q9_checker (.*);

### bench/tb.sv
// Self-checking bench for the D2Q9 BGK cell collision engine.
`timescale 1ns / 1ps

module tb;
    import d2q9_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam logic [D2Q9_ADDR_W-1:0] ADDR_OMEGA = 3'd0;
    localparam logic [D2Q9_ADDR_W-1:0] ADDR_SPARE = 3'd4;

    typedef struct {
        t_q14 f [9];
        logic wall;
    } cell_in_t;

    typedef struct {
        t_q14 g [9];
        t_q14 rho;
        t_q14 vx;
        t_q14 vy;
    } cell_out_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    t_q14 drv_f [9] = '{default: '0};
    logic drv_wall = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [D2Q9_ADDR_W-1:0] paddr = '0;
    logic [D2Q9_DATA_W-1:0] pwdata = '0;
    logic [D2Q9_DATA_W-1:0] prdata;
    logic pready;
    logic full;
    logic empty;
    t_q14 res_g [9];
    t_q14 res_rho, res_vx, res_vy;

    // Values seen at the falling edge, used at the next rising edge.
    logic full_s = 1'b1;
    logic empty_s = 1'b1;
    cell_out_t res_s;

    cell_out_t expected_cells [$];
    logic [14:0] omega_model = D2Q9_OMEGA_RESET;
    int errors = 0;
    int cells_sent = 0;
    int walls_sent = 0;
    int cells_checked = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int pop_stall_pct = 0;

    always #4 i_clk = ~i_clk;

    d2q9_bgk_cell_collide uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_f_rest(drv_f[0]), .i_f_east(drv_f[1]), .i_f_north(drv_f[2]),
        .i_f_west(drv_f[3]), .i_f_south(drv_f[4]), .i_f_northeast(drv_f[5]),
        .i_f_northwest(drv_f[6]), .i_f_southwest(drv_f[7]), .i_f_southeast(drv_f[8]),
        .i_is_wall(drv_wall),
        .empty(empty), .pop(pop),
        .o_g_rest(res_g[0]), .o_g_east(res_g[1]), .o_g_north(res_g[2]),
        .o_g_west(res_g[3]), .o_g_south(res_g[4]), .o_g_northeast(res_g[5]),
        .o_g_northwest(res_g[6]), .o_g_southwest(res_g[7]), .o_g_southeast(res_g[8]),
        .o_density(res_rho), .o_vel_x(res_vx), .o_vel_y(res_vy),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    function automatic longint round_div(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic t_q14 clamp16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic cell_out_t collide_cell(cell_in_t c, logic [14:0] om);
        int cx [9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
        int cy [9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
        int w36 [9] = '{16, 4, 4, 4, 4, 1, 1, 1, 1};
        int opp [9] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
        longint fv [9];
        longint sum, mx, my, rho, ux, uy, uu, cu, t, feq, d;
        cell_out_t r;
        sum = 0;
        mx = 0;
        my = 0;
        ux = 0;
        uy = 0;
        for (int k = 0; k < 9; k++) begin
            fv[k] = longint'(c.f[k]);
        end
        if (c.wall) begin
            for (int k = 0; k < 9; k++) r.g[k] = c.f[opp[k]];
            r.rho = '0;
            r.vx = '0;
            r.vy = '0;
            return r;
        end
        for (int k = 0; k < 9; k++) begin
            sum += fv[k];
            mx += cx[k] * fv[k];
            my += cy[k] * fv[k];
        end
        rho = longint'(clamp16(sum));
        // Velocities stay zero unless the density is positive.
        if (sum > 0) begin
            ux = longint'(clamp16(round_div(mx * 16384, sum)));
            uy = longint'(clamp16(round_div(my * 16384, sum)));
        end
        uu = ux * ux + uy * uy;
        for (int k = 0; k < 9; k++) begin
            cu = cx[k] * ux + cy[k] * uy;
            t = (longint'(1) << 29) + 6 * cu * 16384 + 9 * cu * cu - 3 * uu;
            feq = round_div(rho * w36[k] * t, longint'(72) << 28);
            d = fv[k] - feq;
            r.g[k] = clamp16(fv[k] - round_div(longint'(om) * d, 16384));
        end
        r.rho = rho[15:0];
        r.vx = ux[15:0];
        r.vy = uy[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic compare_cell(cell_out_t got, cell_out_t want);
        string dir_name [9] = '{"rest", "east", "north", "west", "south",
                                "northeast", "northwest", "southwest", "southeast"};
        for (int k = 0; k < 9; k++) begin
            if (got.g[k] !== want.g[k])
                report_mismatch({"g_", dir_name[k]}, got.g[k], want.g[k]);
        end
        if (got.rho !== want.rho) report_mismatch("density", got.rho, want.rho);
        if (got.vx !== want.vx) report_mismatch("vel_x", got.vx, want.vx);
        if (got.vy !== want.vy) report_mismatch("vel_y", got.vy, want.vy);
    endtask

    always @(negedge i_clk) begin
        full_s = full;
        empty_s = empty;
        for (int k = 0; k < 9; k++) res_s.g[k] = res_g[k];
        res_s.rho = res_rho;
        res_s.vx = res_vx;
        res_s.vy = res_vy;
    end

    // Result side: random stalls, checking, and the no-progress watchdog.
    always @(posedge i_clk) begin
        if (pop && !empty_s && i_rst_n) begin
            if (expected_cells.size() == 0) begin
                $display("%0t: result item with nothing expected", $time);
                errors++;
            end else begin
                compare_cell(res_s, expected_cells.pop_front());
                cells_checked++;
            end
        end
        if (i_rst_n && ((pop && !empty_s) || (push && !full_s) || psel)) begin
            idle_cycles = 0;
        end else if (i_rst_n) begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    task automatic send_cell(cell_in_t c, bit given, cell_out_t want);
        bit busy;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        for (int k = 0; k < 9; k++) drv_f[k] <= c.f[k];
        drv_wall <= c.wall;
        do begin
            @(negedge i_clk);
            busy = full;
            @(posedge i_clk);
        end while (busy);
        expected_cells.push_back(given ? want : collide_cell(c, omega_model));
        cells_sent++;
        if (c.wall) walls_sent++;
    endtask

    task automatic drain;
        push <= 1'b0;
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [D2Q9_ADDR_W-1:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_OMEGA) omega_model = data[14:0];
        @(posedge i_clk);
    endtask

    task automatic check_omega;
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_OMEGA;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        got = prdata;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got[14:0] !== omega_model) report_mismatch("relax_omega readback", got, omega_model);
        @(posedge i_clk);
    endtask

    function automatic cell_in_t make_cell(int a0, int a1, int a2, int a3, int a4,
                                           int a5, int a6, int a7, int a8, bit w);
        cell_in_t c;
        c.f = '{a0[15:0], a1[15:0], a2[15:0], a3[15:0], a4[15:0],
                a5[15:0], a6[15:0], a7[15:0], a8[15:0]};
        c.wall = w;
        return c;
    endfunction

    // Mostly near-equilibrium fluid cells; some walls, fully random and negative-mass cells.
    function automatic cell_in_t random_cell();
        int w36 [9] = '{16, 4, 4, 4, 4, 1, 1, 1, 1};
        cell_in_t c;
        int kind, rho, spread;
        kind = $urandom_range(99);
        rho = $urandom_range(30000, 2000);
        spread = (kind < 40) ? rho / 64 : rho / 6;
        for (int k = 0; k < 9; k++) begin
            if (kind >= 80) c.f[k] = t_q14'($urandom);
            else if (kind >= 72) c.f[k] = -t_q14'($urandom_range(4000));
            else c.f[k] = t_q14'(rho * w36[k] / 36 + $urandom_range(2 * spread) - spread);
        end
        c.wall = ($urandom_range(99) < 12);
        return c;
    endfunction

    cell_in_t dir_cells [$];
    bit dir_given [$];
    cell_out_t dir_want [$];

    task automatic add_row(cell_in_t c, bit given, cell_out_t want);
        dir_cells.push_back(c);
        dir_given.push_back(given);
        dir_want.push_back(want);
    endtask

    initial begin
        cell_out_t z, w;
        int phase_omega [5] = '{16384, 0, 32767, 0, 16384};
        int phase_send [5] = '{0, 87, 0, 26, 0};
        int phase_stall [5] = '{0, 0, 87, 26, 0};

        z.g = '{default: '0};
        z.rho = '0;
        z.vx = '0;
        z.vy = '0;
        add_row(make_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, z);
        add_row(make_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, z);
        // Bounce-back swaps opposite pairs and reports zero moments.
        w = z;
        w.g = '{16'sd10, 16'sd4, 16'sd5, 16'sd2, 16'sd3, 16'sd8, 16'sd9, 16'sd6, 16'sd7};
        add_row(make_cell(10, 2, 3, 4, 5, 6, 7, 8, 9, 1), 1, w);
        w.g = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
        add_row(make_cell(32767, 32767, -32768, -32768, 32767,
                          32767, -32768, -32768, 32767, 1), 1, w);
        add_row(make_cell(7282, 1820, 1820, 1820, 1820, 455, 455, 455, 455, 0), 0, z);
        add_row(make_cell(32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767, 32767, 0), 0, z);
        add_row(make_cell(-32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768, -32768, 0), 0, z);
        add_row(make_cell(-1, -1, -1, -1, -1, -1, -1, -1, -1, 0), 0, z);
        add_row(make_cell(7000, 3000, 1800, 900, 1800, 700, 300, 300, 700, 0), 0, z);
        add_row(make_cell(7000, 1800, 3000, 1800, 900, 700, 700, 300, 300, 0), 0, z);
        add_row(make_cell(7000, 900, 1800, 3000, 1800, 200, 600, 900, 300, 0), 0, z);
        add_row(make_cell(0, 32767, 0, 0, 0, 0, 0, 0, 0, 0), 0, z);
        add_row(make_cell(0, 32767, 0, -32766, 0, 0, 0, 0, 0, 0), 0, z);
        add_row(make_cell(0, 0, -32766, 0, 32767, 0, 0, 0, 0, 0), 0, z);
        add_row(make_cell(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, z);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_omega();
        // Writes outside the omega register must leave it alone.
        reg_write(ADDR_SPARE, $urandom);
        check_omega();

        for (int r = 0; r < dir_cells.size(); r++) send_cell(dir_cells[r], dir_given[r], dir_want[r]);

        for (int p = 0; p < 5; p++) begin
            drain();
            reg_write(ADDR_OMEGA, (p == 3) ? $urandom_range(32767) : phase_omega[p]);
            check_omega();
            send_idle_pct = phase_send[p];
            pop_stall_pct = phase_stall[p];
            for (int n = 0; n < 127; n++) begin
                if (p == 4 && n == 60) drain();
                send_cell(random_cell(), 0, z);
            end
        end
        push <= 1'b0;
        pop_stall_pct = 0;
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d cells (%0d walls), %0d results checked,", cells_sent,
                 walls_sent, cells_checked);
        $display("over five omega settings with sender gaps and receiver stalls.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/d2q9_pkg.sv
design/d2q9_front.sv
design/d2q9_fifo.sv
design/d2q9_div.sv
design/d2q9_back.sv
design/d2q9_bgk_cell_collide.sv
design/d2q9_checker.sv
bench/tb.sv
